// ===== src/pts_pkg.sv =====
package pts_pkg;

	// field widths of the request and response beats
	localparam int CMD_W  = 2;
	localparam int WORD_W = 32;
	localparam int IDX_W  = 10;
	localparam int STAT_W = 2;
	localparam int SIZE_W = 11;

	// command codes
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// status of the serial remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} pts_div_stat_t;

endpackage

// ===== src/pts_if.sv =====
// request channel: one command beat
interface pts_req_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [WORD_W-1:0] random_word;
	logic [IDX_W-1:0]  read_index;

	modport source (output valid, command, random_word, read_index, input ready);
	modport sink   (input valid, command, random_word, read_index, output ready);
endinterface

// response channel: one result beat
interface pts_rsp_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  entry_value;
	logic [IDX_W-1:0]  step_position;
	logic [IDX_W-1:0]  partner_index;
	logic              shuffle_done;
	logic [STAT_W-1:0] status;

	modport source (output valid, entry_value, step_position, partner_index, shuffle_done,
		status, input ready);
	modport sink   (input valid, entry_value, step_position, partner_index, shuffle_done,
		status, output ready);
endinterface

// ===== src/pts_ram.sv =====
// simple dual-port RAM, one write and one registered read port
module pts_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pts_mod_serial.sv =====
// bit-serial remainder: dividend mod divisor, one dividend bit per cycle
module pts_mod_serial import pts_pkg::*; #(
	parameter int DW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [DW-1:0]     divisor,
	output logic [DW-1:0]     remainder,
	output pts_div_stat_t     stat
);

	localparam int CW = $clog2(WORD_W);

	logic [WORD_W-1:0] word_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     div_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DW:0] shifted;
	logic [DW:0] diff;

	// shift in the next dividend bit and subtract when it fits
	assign shifted = {rem_q, word_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			word_q <= {word_q[WORD_W-2:0], 1'b0};
			if (shifted >= {1'b0, div_q}) begin
				rem_q <= diff[DW-1:0];
			end else begin
				rem_q <= shifted[DW-1:0];
			end
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// partial remainder stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && div_q != '0) |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	// count is parked at zero between runs
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cnt_q == '0))
		else $error("bit count not parked");

	// done only once the run is over
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done while busy");

endmodule

// ===== src/permutation_table_shuffler.sv =====
// Channel  Dir  Beat contents
// -------  ---  -------------------------------------------------------------
// req      in   command, random_word, read_index
// rsp      out  entry_value, step_position, partner_index, shuffle_done, status
// cfg      in   table_size_we / table_size_wdata, one write per high cycle
//
// A shuffle step runs through accept, the bit-serial remainder over the random word,
// its done cycle with the partner read, two swap writes and result load.
// An in-range read passes accept, the table read and result load; an out-of-range read,
// an unused command or a step after done go from accept straight to result load; a restart refills the table first.
// After reset or a table_size write the table is refilled with the identity, one entry
// per cycle; no request is taken meanwhile.
// A stalled response holds in its output register; the next result then waits and
// blocks the request side.
module permutation_table_shuffler import pts_pkg::*; #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              table_size_we,
	input  logic [SIZE_W-1:0] table_size_wdata,
	pts_req_if.sink           req,
	pts_rsp_if.source         rsp
);

	// the size register cannot exceed 2047, so neither can any used index
	localparam int EFF_MAX    = (MAX_ENTRIES < 2047) ? MAX_ENTRIES : 2047;
	localparam int IW         = $clog2(EFF_MAX);
	localparam int SZW        = $clog2(EFF_MAX + 1);
	localparam int RESET_SIZE = (EFF_MAX < 1024) ? EFF_MAX : 1024;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_DIV   = 7'b0000100,
		S_RDJ   = 7'b0001000,
		S_WRJ   = 7'b0010000,
		S_RDV   = 7'b0100000,
		S_RES   = 7'b1000000
	} state_t;

	state_t         state_q;
	logic [IW-1:0]  clr_q;
	logic           pending_q;
	logic [SZW-1:0] eff_size_q;
	logic [IW-1:0]  next_pos_q;
	logic           out_valid_q;

	logic [IW-1:0]     vi_q;
	logic [IW-1:0]     j_q;
	logic [IW-1:0]     res_value_q;
	logic [IW-1:0]     res_pos_q;
	logic [IW-1:0]     res_part_q;
	logic [STAT_W-1:0] res_status_q;
	logic [IDX_W-1:0]  out_value_q;
	logic [IDX_W-1:0]  out_pos_q;
	logic [IDX_W-1:0]  out_part_q;
	logic              out_done_q;
	logic [STAT_W-1:0] out_status_q;

	logic [SZW-1:0] new_size;
	logic [IW-1:0]  clr_last;
	logic           read_oor;
	logic           accept;
	logic           load;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [IW-1:0] ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [IW-1:0] ram_rdata;

	logic          div_start;
	logic [IW-1:0] div_rem;
	pts_div_stat_t div_stat;

	// effective size of a written register value, clamped to 1..MAX_ENTRIES
	always_comb begin
		if (table_size_wdata == '0) begin
			new_size = SZW'(1);
		end else if (17'(table_size_wdata) > 17'(MAX_ENTRIES)) begin
			new_size = SZW'(EFF_MAX);
		end else begin
			new_size = SZW'(table_size_wdata);
		end
	end

	assign clr_last = IW'(eff_size_q - SZW'(1));
	assign read_oor = 17'(req.read_index) >= 17'(eff_size_q);
	assign accept   = (state_q == S_IDLE) && req.valid;
	assign load     = (state_q == S_RES) && (!out_valid_q || rsp.ready);

	// table port and divider control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = clr_q;
		ram_re    = 1'b0;
		ram_raddr = next_pos_q;
		div_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				if (req.valid) begin
					case (req.command)
						CMD_STEP: begin
							if (next_pos_q != '0) begin
								ram_re    = 1'b1;
								div_start = 1'b1;
							end
						end
						CMD_READ: begin
							if (!read_oor) begin
								ram_re    = 1'b1;
								ram_raddr = IW'(req.read_index);
							end
						end
						default: ;
					endcase
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					ram_re    = 1'b1;
					ram_raddr = div_rem;
				end
			end
			S_RDJ: begin
				ram_we    = 1'b1;
				ram_waddr = next_pos_q;
				ram_wdata = ram_rdata;
			end
			S_WRJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = vi_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pending_q   <= 1'b0;
			eff_size_q  <= SZW'(RESET_SIZE);
			next_pos_q  <= IW'(RESET_SIZE - 1);
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (table_size_we) begin
				eff_size_q <= new_size;
				next_pos_q <= IW'(new_size - SZW'(1));
				state_q    <= S_CLEAR;
				clr_q      <= '0;
				pending_q  <= 1'b0;
			end else begin
				case (state_q)
					S_CLEAR: begin
						if (clr_q == clr_last) begin
							state_q <= pending_q ? S_RES : S_IDLE;
						end else begin
							clr_q <= clr_q + IW'(1);
						end
					end
					S_IDLE: begin
						if (req.valid) begin
							case (req.command)
								CMD_RESTART: begin
									state_q    <= S_CLEAR;
									clr_q      <= '0;
									pending_q  <= 1'b1;
									next_pos_q <= clr_last;
								end
								CMD_STEP: begin
									state_q <= (next_pos_q != '0) ? S_DIV : S_RES;
								end
								CMD_READ: begin
									state_q <= read_oor ? S_RES : S_RDV;
								end
								default: begin
									state_q <= S_RES;
								end
							endcase
						end
					end
					S_DIV: begin
						if (div_stat.done) begin
							state_q <= S_RDJ;
						end
					end
					S_RDJ: begin
						state_q <= S_WRJ;
					end
					S_WRJ: begin
						next_pos_q <= next_pos_q - IW'(1);
						state_q    <= S_RES;
					end
					S_RDV: begin
						state_q <= S_RES;
					end
					S_RES: begin
						if (load) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// result fields and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			res_value_q <= '0;
			res_pos_q   <= '0;
			res_part_q  <= '0;
			if (req.command == CMD_STEP && next_pos_q == '0) begin
				res_status_q <= ST_DONE;
			end else if (req.command == CMD_READ && read_oor) begin
				res_status_q <= ST_RANGE;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if (state_q == S_DIV && div_stat.done) begin
			vi_q <= ram_rdata;
			j_q  <= div_rem;
		end
		if (state_q == S_RDJ || state_q == S_RDV) begin
			res_value_q <= ram_rdata;
		end
		if (state_q == S_WRJ) begin
			res_pos_q  <= next_pos_q;
			res_part_q <= j_q;
		end
		if (load) begin
			out_value_q  <= IDX_W'(res_value_q);
			out_pos_q    <= IDX_W'(res_pos_q);
			out_part_q   <= IDX_W'(res_part_q);
			out_done_q   <= (next_pos_q == '0);
			out_status_q <= res_status_q;
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.entry_value   = out_value_q;
	assign rsp.step_position = out_pos_q;
	assign rsp.partner_index = out_part_q;
	assign rsp.shuffle_done  = out_done_q;
	assign rsp.status        = out_status_q;

	// permutation table
	pts_ram #(
		.WIDTH (IW),
		.DEPTH (EFF_MAX)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// partner index: random word mod current position
	pts_mod_serial #(
		.DW (IW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req.random_word),
		.divisor   (next_pos_q),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	// position pointer stays inside the table
	a_pos_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		next_pos_q < eff_size_q)
		else $error("next position beyond table size");

	// swap partner lies below the swapped position
	a_partner_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRJ) |-> (j_q < next_pos_q))
		else $error("partner not below position");

	// fill pass stays inside the table
	a_clear_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (clr_q < eff_size_q))
		else $error("fill address beyond table size");

	// a finished result shows up on the response port
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rsp.valid)
		else $error("result not presented");

	// remainder unit runs for the whole divide state
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("divide state without a running remainder");

endmodule
